/* rtl/core/cdl_pkg.sv */
// Shared types and constants for the cascaded delay-line word loader.
package cdl_pkg;

  localparam int unsigned DELAY_W     = 20;
  localparam int unsigned WORD_BITS   = 24;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned STEPS_W     = 10;
  localparam int unsigned STAGE_W     = 8;
  localparam int unsigned STAGE_FULL  = 255;
  localparam int unsigned STAGE_STEPS = 256;
  localparam int unsigned MAX_STEPS   = 767;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DELAY_W-1:0]   delay_t;
  typedef logic [POS_W-1:0]     pos_t;

endpackage

/* rtl/core/cdl_front.sv */
// Front end: accepts a delay, divides it by the step size and builds the stage word.
module cdl_front #(
  parameter int unsigned STEP_PS = 250
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cdl_pkg::delay_t delay_ps,
  input  logic           full,
  output logic           busy,
  output logic           push,
  output cdl_pkg::word_t word
);
  import cdl_pkg::*;

  localparam int unsigned RECIP_W   = DELAY_W + 1;
  localparam int unsigned SHIFT     = DELAY_W + $clog2(STEP_PS);
  localparam int unsigned PROD_W    = DELAY_W + RECIP_W;
  localparam int unsigned SAT_LIMIT = (MAX_STEPS + 1) * STEP_PS;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(STEP_PS) - 64'd1) / 64'(STEP_PS);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_DONE} state_t;

  state_t             state;
  delay_t             dly;
  logic               sat;
  logic [STEPS_W-1:0] steps;
  logic [PROD_W-1:0]  prod;
  logic               take;

  function automatic word_t build_word(input logic [STEPS_W-1:0] s);
    word_t w;
    if (s <= STEPS_W'(STAGE_FULL)) begin
      w = WORD_BITS'(s);
    end else if (s < STEPS_W'(2 * STAGE_STEPS)) begin
      w = WORD_BITS'(STAGE_FULL)
        + (WORD_BITS'(s - STEPS_W'(STAGE_STEPS)) << STAGE_W);
    end else begin
      w = WORD_BITS'((STAGE_STEPS * STAGE_STEPS) - 1)
        + (WORD_BITS'(s - STEPS_W'(2 * STAGE_STEPS)) << (2 * STAGE_W));
    end
    return w;
  endfunction

  assign busy  = (state == S_CALC) || ((state == S_DONE) && full);
  assign push  = (state == S_DONE) && !full;
  assign take  = start && !busy;
  assign prod  = PROD_W'(dly) * PROD_W'(RECIP_C);
  assign word  = build_word(steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          steps <= sat ? STEPS_W'(MAX_STEPS) : prod[SHIFT +: STEPS_W];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!full) begin
            state <= take ? S_CALC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (take) begin
        dly <= delay_ps;
        sat <= delay_ps >= DELAY_W'(SAT_LIMIT);
      end
    end
  end

endmodule

/* rtl/core/cdl_fifo.sv */
// Two-entry word queue between the front end and the serialiser.
module cdl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdl_pkg::word_t push_word,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output cdl_pkg::word_t pop_word
);
  import cdl_pkg::*;

  word_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/cdl_back.sv */
// Back end: shifts each stage word out one bit per cycle, most significant first.
module cdl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  cdl_pkg::word_t pop_word,
  output logic           pop,
  output logic           strobe,
  output logic           data_bit,
  output cdl_pkg::pos_t  bit_position,
  output cdl_pkg::word_t stage_word,
  output logic           latch_enable,
  output logic           last_bit
);
  import cdl_pkg::*;

  logic  active;
  pos_t  pos;
  word_t word;
  logic  at_end;

  assign at_end       = pos == '0;
  assign pop          = !empty && (!active || at_end);
  assign strobe       = active;
  assign data_bit     = word[pos];
  assign bit_position = pos;
  assign stage_word   = word;
  assign latch_enable = active;
  assign last_bit     = active && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      pos    <= POS_W'(WORD_BITS - 1);
      word   <= pop_word;
    end else if (active) begin
      if (at_end) begin
        active <= 1'b0;
      end else begin
        pos <= pos - POS_W'(1);
      end
    end
  end

endmodule

/* rtl/core/cascaded_delay_line_word_loader.sv */
// Cascaded delay-line word loader: delay in picoseconds to a serial 24-bit stage word.
//
// Each accepted delay yields 24 results on consecutive cycles, bit 23 first, each
// marked by strobe with latch_enable high; last_bit marks bit 0. With the queue empty
// and the serialiser idle, the first bit reaches the ports once the delay has been
// turned into a step count by reciprocal multiplication, the word has been written
// into the queue and the serialiser has loaded it. The front end takes no new delay
// while it computes a step count or while its word waits for room in the queue, and
// words queue two deep, so it takes a new delay while earlier words are still shifting;
// sustained throughput is set by the one-bit-per-cycle serialiser, and consecutive
// queued words leave without a gap. Results cannot be held off: the receiver must
// take each strobe as it comes.
module cascaded_delay_line_word_loader #(
  parameter int unsigned STEP_PS = 250
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cdl_pkg::delay_t delay_ps,
  output logic            busy,
  output logic            strobe,
  output logic            data_bit,
  output cdl_pkg::pos_t   bit_position,
  output cdl_pkg::word_t  stage_word,
  output logic            latch_enable,
  output logic            last_bit
);
  import cdl_pkg::*;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  word_t f_word;
  word_t q_word;

  cdl_front #(
    .STEP_PS (STEP_PS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .delay_ps (delay_ps),
    .full     (q_full),
    .busy     (busy),
    .push     (q_push),
    .word     (f_word)
  );

  cdl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (f_word),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_word  (q_word)
  );

  cdl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .pop_word     (q_word),
    .pop          (q_pop),
    .strobe       (strobe),
    .data_bit     (data_bit),
    .bit_position (bit_position),
    .stage_word   (stage_word),
    .latch_enable (latch_enable),
    .last_bit     (last_bit)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_run_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_bit |=> strobe
      && (bit_position == POS_W'($past(bit_position) - POS_W'(1)))
      && $stable(stage_word))
    else $error("serial run broken before last bit");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> strobe && (bit_position == POS_W'(WORD_BITS - 1)))
    else $error("run does not start at top bit");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded delay-line word loader: random bursts of delays, serial bits checked against a predicted word.
module tb;
  import cdl_pkg::*;

  localparam int unsigned STEP_PS    = 250;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned N_RANDOM   = 140;
  localparam int unsigned TAIL       = 40;

  typedef struct packed {
    logic  data_bit;
    pos_t  bit_position;
    word_t stage_word;
    logic  latch_enable;
    logic  last_bit;
  } serial_bit_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  delay_t delay_ps = '0;
  logic   busy;
  logic   strobe;
  logic   data_bit;
  pos_t   bit_position;
  word_t  stage_word;
  logic   latch_enable;
  logic   last_bit;

  delay_t      pending_delays[$];
  serial_bit_t expected_bits[$];
  int unsigned n_items = 0;
  int unsigned n_transfers = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic        xfer_done = 1'b0;

  cascaded_delay_line_word_loader #(.STEP_PS(STEP_PS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .delay_ps(delay_ps),
    .busy(busy),
    .strobe(strobe),
    .data_bit(data_bit),
    .bit_position(bit_position),
    .stage_word(stage_word),
    .latch_enable(latch_enable),
    .last_bit(last_bit)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic word_t stage_word_for(delay_t d);
    int unsigned steps;
    steps = d / STEP_PS;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    if (steps <= STAGE_FULL) return word_t'(steps);
    if (steps < 2 * STAGE_STEPS)
      return word_t'(STAGE_FULL + ((steps - STAGE_STEPS) << STAGE_W));
    return word_t'(((STAGE_FULL << STAGE_W) | STAGE_FULL) +
                   ((steps - 2 * STAGE_STEPS) << (2 * STAGE_W)));
  endfunction

  task automatic push_serial_bits(delay_t d);
    word_t       w;
    serial_bit_t b;
    w = stage_word_for(d);
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      b.data_bit     = w[k];
      b.bit_position = pos_t'(k);
      b.stage_word   = w;
      b.latch_enable = 1'b1;
      b.last_bit     = (k == 0);
      expected_bits.push_back(b);
    end
  endtask

  task automatic compare_field(string name, logic [WORD_BITS-1:0] exp_v,
                               logic [WORD_BITS-1:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Driver: hold start until the transfer, then burst or pause.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !xfer_done) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_delays.size() != 0) begin
      start <= 1'b1;
      delay_ps <= pending_delays.pop_front();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 1);
        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(50, 1);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: record transfers, check each strobed bit against the oldest expectation.
  always @(posedge clk) begin
    serial_bit_t e;
    if (rst) begin
      xfer_done = 1'b0;
    end else begin
      xfer_done = start && !busy;
      if (xfer_done) begin
        n_transfers++;
        push_serial_bits(delay_ps);
      end
      if (strobe === 1'b1) begin
        if (expected_bits.size() == 0) begin
          err_count++;
          $display("%0t unexpected result: expected none, actual bit %0d of word %0h",
                   $time, bit_position, stage_word);
        end else begin
          e = expected_bits.pop_front();
          compare_field("data_bit", word_t'(e.data_bit), word_t'(data_bit));
          compare_field("bit_position", word_t'(e.bit_position), word_t'(bit_position));
          compare_field("stage_word", e.stage_word, stage_word);
          compare_field("latch_enable", word_t'(e.latch_enable), word_t'(latch_enable));
          compare_field("last_bit", word_t'(e.last_bit), word_t'(last_bit));
        end
      end else if (strobe !== 1'b0) begin
        err_count++;
        $display("%0t strobe mismatch: expected 0 or 1, actual %b", $time, strobe);
      end
      if (xfer_done || strobe === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned bound;
    delay_t d;
    pending_delays = '{
      20'd0, 20'd1, 20'd249, 20'd250, 20'd63750, 20'd63999, 20'd64000, 20'd64250,
      20'd127750, 20'd127999, 20'd128000, 20'd128250, 20'd191750, 20'd191999,
      20'd192000, 20'd500000, 20'hFFFFF, 20'h80000, 20'h55555, 20'hAAAAA, 20'd25000
    };
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
        d = delay_t'($urandom_range(193000, 0));
      end else if (pick < 7) begin
        bound = $urandom_range(3, 0) * STAGE_STEPS;
        d = delay_t'(bound * STEP_PS + $urandom_range(3 * STEP_PS, 0) - STEP_PS);
        if (bound == 0) d = delay_t'($urandom_range(2 * STEP_PS, 0));
      end else begin
        d = delay_t'($urandom);
      end
      pending_delays.push_back(d);
    end
    n_items = pending_delays.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (n_transfers < n_items) @(posedge clk);
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* cascaded_delay_line_word_loader.f */
rtl/core/cdl_pkg.sv
rtl/core/cdl_front.sv
rtl/core/cdl_fifo.sv
rtl/core/cdl_back.sv
rtl/core/cascaded_delay_line_word_loader.sv
tb/tb.sv
